// ===== src/interleaved_channel_moving_average_defines.svh =====
// Assertion macros for the interleaved channel moving average block.
// Used by the port checker; no other dependencies.
`ifndef INTERLEAVED_CHANNEL_MOVING_AVERAGE_DEFINES_SVH
`define INTERLEAVED_CHANNEL_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icma check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ICMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icma check failed");

`endif

// ===== src/icma_pkg.sv =====
// Shared types and constants for the interleaved channel moving average.
// No dependencies.
package icma_pkg;

    localparam int unsigned RAW_W     = 16;
    localparam int unsigned SAMPLE_W  = 10;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned MEAN_W    = 16;
    localparam int unsigned TOTAL_W   = 18;
    localparam int unsigned NEXT_W    = 2;
    localparam int unsigned FRAC_BITS = 6;
    localparam int unsigned OUT_MEANS = 3;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_FIELD_W = OUT_MEANS * MEAN_W + TOTAL_W + NEXT_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [MEAN_W-1:0]   t_mean;
    typedef logic [TOTAL_W-1:0]  t_total;
    typedef logic [NEXT_W-1:0]   t_next;

endpackage

// ===== src/interleaved_channel_moving_average.sv =====
// Channel   Dir  Fields (tdata, low bit up)
// s         in   raw_conversion[15:0]
// m         out  average_ch0[15:0] average_ch1[31:16] average_ch2[47:32]
//                total_weight[65:48] next_channel[67:66] zero[71:68]
//
// One sample per cycle unless the output stalls; each passes stage 1, then 2.
// Stage 1 updates the channel sum from the pre-read ring slot; stage 2 holds
// the means. The ring RAM is read one slot ahead so its registered read port
// never stalls. Reset (i_rst_n, synchronous) clears sums and pointers; ring
// slots not yet written read as zero. An output stall backs up into s tready.
//
// Top level: ring of samples, running sums, mean unit and output register.
// Depends on icma_pkg, icma_ram and icma_mean.
module interleaved_channel_moving_average #(
    parameter int unsigned CHANNELS            = 3,
    parameter int unsigned SAMPLES_PER_CHANNEL = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [icma_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // raw_conversion
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // average_ch0, average_ch1, average_ch2, total_weight, next_channel, zero pad
    output logic [icma_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import icma_pkg::*;

    localparam int unsigned RING   = CHANNELS * SAMPLES_PER_CHANNEL;
    localparam int unsigned SLOT_W = (RING > 1) ? $clog2(RING) : 1;
    localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING - 1);
    localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);

    // ring pointers
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CH_W-1:0]   r_chan, n_chan;
    logic              r_full;
    logic              r_byp;
    t_sample           r_byp_data;

    // stage 1: sums and the request's next channel
    t_sum  r_sums [CHANNELS];
    logic  r_s1_valid;
    t_next r_s1_next;

    // stage 2: output register
    logic   r_out_valid;
    t_mean  r_out_avg [OUT_MEANS];
    t_total r_out_total;
    t_next  r_out_next;

    logic    w_accept, w_s1_move, w_s2_ready;
    t_sample w_sample, w_ram_rdata, w_old;
    t_sum    w_new_sum;
    t_mean   w_avg [OUT_MEANS];
    t_total  w_total;

    assign w_s2_ready = !r_out_valid || i_m_tready;
    assign w_s1_move  = r_s1_valid && w_s2_ready;
    assign o_s_tready = !r_s1_valid || w_s2_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_sample = i_s_tdata[SAMPLE_W-1:0];

    always_comb begin
        n_slot = r_slot;
        n_chan = r_chan;
        if (w_accept) begin
            n_slot = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
            n_chan = (r_chan == CH_LAST) ? '0 : r_chan + 1'b1;
        end
    end

    // read one slot ahead; bypass when the next slot is the one being written
    icma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING),
        .AW    (SLOT_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_slot),
        .i_wdata (w_sample),
        .i_raddr (n_slot),
        .o_rdata (w_ram_rdata)
    );

    assign w_old     = !r_full ? '0 : (r_byp ? r_byp_data : w_ram_rdata);
    assign w_new_sum = r_sums[r_chan] - SUM_W'(w_old) + SUM_W'(w_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_chan <= '0;
            r_full <= 1'b0;
            r_byp  <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_sums[k] <= '0;
            end
        end else begin
            r_slot <= n_slot;
            r_chan <= n_chan;
            r_byp  <= w_accept && (n_slot == r_slot);
            if (w_accept && (r_slot == SLOT_LAST)) begin
                r_full <= 1'b1;
            end
            if (w_accept) begin
                r_sums[r_chan] <= w_new_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= w_sample;
        if (w_accept) begin
            r_s1_next <= NEXT_W'(n_chan);
        end
    end

    icma_mean #(
        .CHANNELS            (CHANNELS),
        .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL)
    ) u_mean (
        .i_sums    (r_sums),
        .o_average (w_avg),
        .o_total   (w_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_avg   <= w_avg;
            r_out_total <= w_total;
            r_out_next  <= r_s1_next;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_next, r_out_total,
                                      r_out_avg[2], r_out_avg[1], r_out_avg[0]});

endmodule

// ===== src/icma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module icma_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 48,
    parameter int unsigned AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/icma_mean.sv =====
// Window mean per channel (sum * 64 / window, by reciprocal multiply) and
// the saturated total of all channel means. Depends on icma_pkg.
module icma_mean #(
    parameter int unsigned CHANNELS            = 3,
    parameter int unsigned SAMPLES_PER_CHANNEL = 16
) (
    input  icma_pkg::t_sum   i_sums [CHANNELS],
    output icma_pkg::t_mean  o_average [icma_pkg::OUT_MEANS],
    output icma_pkg::t_total o_total
);
    import icma_pkg::*;

    // floor(x / d) for x < 2^(SUM_W+FRAC_BITS) via ceil(2^k / d), k = N + ceil(log2 d)
    localparam int unsigned LOG_D  = $clog2(SAMPLES_PER_CHANNEL);
    localparam int unsigned SHIFT  = SUM_W + FRAC_BITS + LOG_D;
    localparam longint unsigned MULT_L =
        ((64'd1 << SHIFT) + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL;
    localparam int unsigned MULT_W = SUM_W + FRAC_BITS + 1;
    localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);
    localparam int unsigned PROD_W = SUM_W + MULT_W;
    localparam int unsigned QSHIFT = SHIFT - FRAC_BITS;
    localparam int unsigned ACC_W  = MEAN_W + $clog2(CHANNELS + 1);

    t_mean w_means [CHANNELS];
    logic [ACC_W-1:0] w_acc;

    for (genvar k = 0; k < CHANNELS; k++) begin : g_mean
        logic [PROD_W-1:0] w_prod;
        assign w_prod     = PROD_W'(i_sums[k]) * PROD_W'(MULT);
        assign w_means[k] = w_prod[QSHIFT +: MEAN_W];
    end

    for (genvar k = 0; k < OUT_MEANS; k++) begin : g_out
        if (k < CHANNELS) begin : g_used
            assign o_average[k] = w_means[k];
        end else begin : g_unused
            assign o_average[k] = '0;
        end
    end

    always_comb begin
        w_acc = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            w_acc = w_acc + ACC_W'(w_means[k]);
        end
    end

    assign o_total = (w_acc > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(w_acc);

endmodule

// ===== src/icma_checker.sv =====
// Port-level checks for the interleaved channel moving average, bound to the
// top level. Depends on icma_pkg and the assertion macro header.
`include "interleaved_channel_moving_average_defines.svh"

module icma_checker #(
    parameter int unsigned CHANNELS = 3
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [icma_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import icma_pkg::*;

    localparam int unsigned NEXT_LO = OUT_MEANS * MEAN_W + TOTAL_W;
    localparam int unsigned TOT_LO  = OUT_MEANS * MEAN_W;
    localparam int unsigned PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    t_next  w_next;
    t_next  w_exp_next;
    t_total w_mean_sum;
    t_next  r_last_next;
    logic   r_seen;

    assign w_next     = o_m_tdata[NEXT_LO +: NEXT_W];
    assign w_exp_next = (r_last_next == NEXT_W'(CHANNELS - 1)) ? '0 : r_last_next + 1'b1;
    assign w_mean_sum = TOTAL_W'(o_m_tdata[0 +: MEAN_W]) +
                        TOTAL_W'(o_m_tdata[MEAN_W +: MEAN_W]) +
                        TOTAL_W'(o_m_tdata[2*MEAN_W +: MEAN_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_m_tvalid && i_m_tready) begin
            r_seen <= 1'b1;
        end
        if (o_m_tvalid && i_m_tready) begin
            r_last_next <= w_next;
        end
    end

    // a stalled result holds
    `ICMA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata))

    // the input stalls only behind a held result
    `ICMA_ASSERT_SAME(a_in_stall, i_clk, i_rst_n, i_s_tvalid && !o_s_tready,
        o_m_tvalid && !i_m_tready)

    // total equals the sum of the three means when no channel is left out
    `ICMA_ASSERT_SAME(a_total_sum, i_clk, i_rst_n, o_m_tvalid,
        (CHANNELS > 3) || (o_m_tdata[TOT_LO +: TOTAL_W] == w_mean_sum))

    // next channel walks round the channels, one step per result
    `ICMA_ASSERT_SAME(a_next_walk, i_clk, i_rst_n, o_m_tvalid && r_seen,
        (CHANNELS > 4) || (w_next == w_exp_next))

    // pad bits are zero
    `ICMA_ASSERT_SAME(a_pad_zero, i_clk, i_rst_n, o_m_tvalid,
        (PAD_W == 0) || (o_m_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0))

endmodule

bind interleaved_channel_moving_average icma_checker #(.CHANNELS(CHANNELS)) u_icma_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for interleaved_channel_moving_average: drives raw ADC words into the
// stream input and checks every averaged result against a behavioral model of the ring.
// Depends on icma_pkg and the RTL top level only.
module testbench;
    import icma_pkg::*;

    localparam int unsigned CHANNELS     = 3;
    localparam int unsigned SAMPLES      = 16;
    localparam int unsigned RING_SIZE    = CHANNELS * SAMPLES;
    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned UPPER_W      = RAW_W - SAMPLE_W;
    localparam t_sample     SAMPLE_MAX   = '1;
    localparam int unsigned N_CORNER     = 12;
    localparam logic [RAW_W-1:0] CORNER_RAW [N_CORNER] = '{
        16'h0000, 16'hFFFF, 16'h03FF, 16'hFC00, 16'h0001, 16'h0200,
        16'h01FF, 16'hAAAA, 16'h5555, 16'h8000, 16'h0400, 16'h7BFE
    };

    typedef enum int unsigned {
        SEG_NOISE, SEG_FULL_SCALE, SEG_ZERO, SEG_LEVELS, SEG_EDGES
    } t_seg_kind;

    typedef enum int unsigned {
        RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC
    } t_rx_mode;

    typedef struct {
        t_mean  mean0;
        t_mean  mean1;
        t_mean  mean2;
        t_total weight;
        t_next  next_ch;
    } t_average_set;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;    // raw_conversion
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // average_ch0, average_ch1, average_ch2, total_weight, next_channel, zero pad
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    bit          hold_off;
    int unsigned n_req;
    int unsigned n_holdoffs;
    int unsigned sender_burst_left;

    class channel_average_board;
        t_sample      ring [RING_SIZE];
        t_sum         sums [CHANNELS];
        int unsigned  slot;
        int unsigned  mismatches;
        int unsigned  results_checked;
        int unsigned  peak_sum;
        t_average_set pending_averages [$];

        function new();
            foreach (ring[i]) ring[i] = '0;
            foreach (sums[i]) sums[i] = '0;
            slot = 0;
            mismatches = 0;
            results_checked = 0;
            peak_sum = 0;
        endfunction

        function t_mean window_mean(input t_sum s);
            int unsigned w;
            w = (32'(s) << FRAC_BITS) / SAMPLES;
            return t_mean'(w);
        endfunction

        function t_mean channel_mean(input int unsigned k);
            if (k < CHANNELS) return window_mean(sums[k]);
            return '0;
        endfunction

        function void log_sample(input logic [RAW_W-1:0] raw);
            t_sample      s;
            int unsigned  ch;
            int unsigned  total;
            t_average_set a;
            s  = raw[SAMPLE_W-1:0];
            ch = slot % CHANNELS;
            sums[ch] = sums[ch] - t_sum'(ring[slot]) + t_sum'(s);
            ring[slot] = s;
            slot = (slot + 1) % RING_SIZE;
            if (32'(sums[ch]) > peak_sum) peak_sum = 32'(sums[ch]);
            total = 0;
            for (int unsigned k = 0; k < CHANNELS; k++) total += 32'(window_mean(sums[k]));
            if (total > 32'(TOTAL_MAX)) total = 32'(TOTAL_MAX);
            a.mean0   = channel_mean(0);
            a.mean1   = channel_mean(1);
            a.mean2   = channel_mean(2);
            a.weight  = t_total'(total);
            a.next_ch = t_next'(slot % CHANNELS);
            pending_averages.push_back(a);
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= 30) $display("ERROR: %s", msg);
        endtask

        task check_field(input string name, input int unsigned got, input int unsigned want);
            if (got != want)
                report($sformatf("result %0d %s: got %0d, want %0d",
                                 results_checked, name, got, want));
        endtask

        task check_averages(input logic [OUT_TDATA_W-1:0] tdata);
            t_average_set w;
            if (pending_averages.size() == 0) begin
                report($sformatf("unrequested result, tdata %h", tdata));
            end else begin
                w = pending_averages.pop_front();
                check_field("average_ch0", 32'(tdata[0 +: MEAN_W]), 32'(w.mean0));
                check_field("average_ch1", 32'(tdata[MEAN_W +: MEAN_W]), 32'(w.mean1));
                check_field("average_ch2", 32'(tdata[2*MEAN_W +: MEAN_W]), 32'(w.mean2));
                check_field("total_weight", 32'(tdata[3*MEAN_W +: TOTAL_W]),
                            32'(w.weight));
                check_field("next_channel", 32'(tdata[3*MEAN_W+TOTAL_W +: NEXT_W]),
                            32'(w.next_ch));
            end
            results_checked++;
        endtask

        task flag_leftovers();
            if (pending_averages.size() != 0)
                report($sformatf("%0d results never arrived", pending_averages.size()));
        endtask
    endclass

    channel_average_board board = new();

    interleaved_channel_moving_average #(
        .CHANNELS            (CHANNELS),
        .SAMPLES_PER_CHANNEL (SAMPLES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                board.log_sample(i_s_tdata);
                n_req++;
            end
            if (o_m_tvalid && i_m_tready) board.check_averages(o_m_tdata);
        end
    end

    // Called at a falling edge; returns at a falling edge after the request is taken.
    task automatic offer_sample(input logic [RAW_W-1:0] raw);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= raw;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (sender_burst_left == 0) begin
            sender_burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= IN_TDATA_W'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
        sender_burst_left--;
    endtask

    // Output side: the stall pattern switches between randomly chosen modes.
    initial begin
        t_rx_mode    mode;
        int unsigned left;
        int unsigned tick;
        bit          rdy;
        i_m_tready = 1'b0;
        mode = RX_ALWAYS;
        left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                left = $urandom_range(20, 120);
            end
            left--;
            tick++;
            case (mode)
                RX_ALWAYS:   rdy = 1'b1;
                RX_MOSTLY:   rdy = ($urandom_range(0, 3) != 0);
                RX_SPARSE:   rdy = ($urandom_range(0, 9) < 3);
                default:     rdy = ((tick % 5) < 2);
            endcase
            i_m_tready <= rdy && !hold_off;
        end
    end

    // Long output hold-offs so the pipeline fills and backs up into s tready.
    initial begin
        hold_off = 1'b0;
        n_holdoffs = 0;
        for (int unsigned h = 0; h < 2; h++) begin
            while (n_req < 300 + h * 500) @(posedge i_clk);
            hold_off = 1'b1;
            n_holdoffs++;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off = 1'b0;
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout: run did not complete");
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_seg_kind            kind;
        int unsigned          seg_left;
        int unsigned          ch;
        logic [UPPER_W-1:0]   upper;
        logic [RAW_W-1:0]     raw;
        t_sample              level [CHANNELS];
        t_sample              edge_vals [6];
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        n_req      = 0;
        sender_burst_left = 0;
        seg_left   = 0;
        kind       = SEG_NOISE;
        edge_vals  = '{10'h000, 10'h001, 10'h1FF, 10'h200, 10'h3FE, 10'h3FF};
        foreach (level[c]) level[c] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (CORNER_RAW[i]) begin
            pace_sender();
            offer_sample(CORNER_RAW[i]);
        end

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                kind = t_seg_kind'($urandom_range(0, 4));
                case (kind)
                    SEG_NOISE:      seg_left = $urandom_range(1, 40);
                    SEG_FULL_SCALE: seg_left = $urandom_range(RING_SIZE, 2 * RING_SIZE);
                    SEG_ZERO:       seg_left = $urandom_range(RING_SIZE, 2 * RING_SIZE);
                    SEG_LEVELS: begin
                        seg_left = $urandom_range(20, 80);
                        foreach (level[c]) level[c] = t_sample'($urandom);
                    end
                    default:        seg_left = $urandom_range(5, 30);
                endcase
            end
            seg_left--;
            upper = UPPER_W'($urandom);
            ch = ((N_CORNER + n) % RING_SIZE) % CHANNELS;
            case (kind)
                SEG_NOISE:      raw = RAW_W'($urandom);
                SEG_FULL_SCALE: raw = {upper, SAMPLE_MAX};
                SEG_ZERO:       raw = {upper, t_sample'(0)};
                SEG_LEVELS:     raw = {upper, level[ch]};
                default:        raw = {upper, edge_vals[$urandom_range(0, 5)]};
            endcase
            pace_sender();
            offer_sample(raw);
        end
        i_s_tvalid <= 1'b0;

        while (board.pending_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        board.flag_leftovers();

        $display("Covered %0d samples and %0d averaged results, %0d long output hold-offs.",
                 n_req, board.results_checked, n_holdoffs);
        $display("Largest channel window sum reached: %0d (full scale %0d).",
                 board.peak_sum, SAMPLES * 32'(SAMPLE_MAX));
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/icma_pkg.sv
src/icma_ram.sv
src/icma_mean.sv
src/interleaved_channel_moving_average.sv
src/icma_checker.sv
bench/testbench.sv
